// ----- hw/rtl/crrp_pkg.sv -----
package crrp_pkg;

    localparam int EVENT_W    = 32;
    localparam int TICK_W     = 8;
    localparam int LIMIT_W    = 16;
    localparam int WAIT_W     = LIMIT_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_USER_W = 2;

    // action codes
    localparam logic [2:0] ACT_PULSE   = 3'd0;
    localparam logic [2:0] ACT_TICK    = 3'd1;
    localparam logic [2:0] ACT_POLL    = 3'd2;
    localparam logic [2:0] ACT_PARTIAL = 3'd3;
    localparam logic [2:0] ACT_GOOD    = 3'd4;
    localparam logic [2:0] ACT_BAD     = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_ACCEPT  = 2'd2;
    localparam logic [1:0] KIND_ABANDON = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_BEFORE_REPORT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_WAIT_LIMIT = 2'd1;

    localparam logic [TICK_W-1:0]  TICKS_RESET = 8'd8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1000;

    localparam logic [7:0] FT_DATA   = 8'h90;
    localparam logic [7:0] FT_STATUS = 8'h8B;

    localparam logic [1:0] MAX_RETRY = 2'd3;

    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_W = 8'h57;
    localparam logic [7:0] CH_S = 8'h53;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] frame_type;
        logic [7:0] delivery_status;
        logic [7:0] first_data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         message_kind;
        logic [7:0]         command_char;
        logic [EVENT_W-1:0] count_value;
        logic [7:0]         check_byte;
        logic               keep_awake;
    } result_t;

    typedef struct packed {
        logic [TICK_W-1:0]  ticks_before_report;
        logic [LIMIT_W-1:0] response_wait_limit;
    } cfg_t;

endpackage

// ----- hw/rtl/crrp_cfg_regs.sv -----
module crrp_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [crrp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [crrp_pkg::CFG_DATA_W-1:0]      cfg_data,
    output crrp_pkg::cfg_t                       cfg
);
    import crrp_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_before_report <= TICKS_RESET;
            cfg_reg.response_wait_limit <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TICKS_BEFORE_REPORT:
                    cfg_reg.ticks_before_report <= cfg_data[TICK_W-1:0];
                REG_RESPONSE_WAIT_LIMIT:
                    cfg_reg.response_wait_limit <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- hw/rtl/crrp_core.sv -----
module crrp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  crrp_pkg::in_item_t item,
    input  crrp_pkg::cfg_t    cfg,
    output logic              res_valid,
    output crrp_pkg::result_t res
);
    import crrp_pkg::*;

    logic [EVENT_W-1:0] event_reg, event_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic               busy_reg, busy_next;
    logic [EVENT_W-1:0] snap_reg, snap_next;
    logic [7:0]         cmd_reg, cmd_next;
    logic [1:0]         retry_reg, retry_next;
    logic               deliv_reg, deliv_next;
    logic               seen_reg, seen_next;
    logic [WAIT_W-1:0]  wait_reg, wait_next;
    logic               awake_reg, awake_next;

    logic [EVENT_W-1:0] ev_after;
    logic [TICK_W-1:0]  tk_after;
    logic [1:0]         retry_inc;
    logic               bump_done;
    logic               link_ev, proceed, rdy, err, tmo, done, send;
    logic               d_v, s_v;

    function automatic logic [7:0] check_of(input logic [EVENT_W-1:0] v);
        logic [9:0] s;
        s = {2'b00, v[7:0]} + {2'b00, v[15:8]} + {2'b00, v[23:16]} + {2'b00, v[31:24]};
        return 8'(10'd0 - s);
    endfunction

    assign retry_inc = (retry_reg < MAX_RETRY) ? retry_reg + 2'd1 : retry_reg;
    assign bump_done = (retry_inc == MAX_RETRY);
    assign link_ev   = fire && busy_reg && (item.action == ACT_POLL
                       || item.action == ACT_PARTIAL || item.action == ACT_GOOD
                       || item.action == ACT_BAD);

    always_comb
    begin
        event_next = event_reg;
        tick_next  = tick_reg;
        busy_next  = busy_reg;
        snap_next  = snap_reg;
        cmd_next   = cmd_reg;
        retry_next = retry_reg;
        deliv_next = deliv_reg;
        seen_next  = seen_reg;
        wait_next  = wait_reg;
        awake_next = awake_reg;
        res_valid  = 1'b0;
        res        = '0;
        ev_after   = event_reg + ((item.action == ACT_PULSE) ? 32'd1 : 32'd0);
        tk_after   = tick_reg + ((item.action == ACT_TICK) ? 8'd1 : 8'd0);
        proceed    = 1'b0;
        rdy        = 1'b0;
        err        = 1'b0;
        tmo        = 1'b0;
        done       = 1'b0;
        send       = 1'b0;
        d_v        = deliv_reg;
        s_v        = seen_reg;

        // counting and report start
        if (fire && (item.action == ACT_PULSE || item.action == ACT_TICK))
        begin
            event_next = ev_after;
            tick_next  = tk_after;
            if (!busy_reg && tk_after > cfg.ticks_before_report)
            begin
                tick_next             = '0;
                busy_next             = 1'b1;
                snap_next             = ev_after;
                cmd_next              = CH_C;
                retry_next            = '0;
                wait_next             = '0;
                deliv_next            = 1'b0;
                seen_next             = 1'b0;
                res_valid             = 1'b1;
                res.message_kind      = KIND_DATA;
                res.command_char      = CH_C;
                res.count_value       = ev_after;
                res.check_byte        = check_of(ev_after);
                res.keep_awake        = awake_reg;
            end
        end

        // link events during a report cycle
        if (link_ev)
        begin
            if (item.action == ACT_POLL)
            begin
                if (wait_reg > {1'b0, cfg.response_wait_limit})
                begin
                    wait_next = '0;
                    tmo       = 1'b1;
                    d_v       = 1'b0;
                    s_v       = 1'b0;
                    proceed   = 1'b1;
                end
                else
                    wait_next = wait_reg + 1'b1;
            end
            else
            begin
                wait_next = '0;
                if (item.action != ACT_PARTIAL)
                begin
                    proceed = 1'b1;
                    if (item.action == ACT_GOOD && item.frame_type == FT_DATA)
                        rdy = 1'b1;
                    else if (item.frame_type == FT_STATUS)
                    begin
                        d_v = (item.action == ACT_GOOD) && (item.delivery_status == 8'd0);
                        s_v = 1'b1;
                    end
                    else
                    begin
                        err = 1'b1;
                        d_v = 1'b0;
                        s_v = 1'b0;
                    end
                end
            end

            if (proceed)
            begin
                if (d_v)
                begin
                    if (rdy)
                    begin
                        if (item.first_data_byte == CH_N)
                        begin
                            done       = bump_done;
                            retry_next = retry_inc;
                            cmd_next   = CH_N;
                            send       = 1'b1;
                            rdy        = 1'b0;
                        end
                        else if (item.first_data_byte == CH_A)
                        begin
                            event_next = event_reg - snap_reg;
                            done       = 1'b1;
                            rdy        = 1'b0;
                        end
                    end
                    else if (err)
                    begin
                        done       = bump_done;
                        retry_next = retry_inc;
                        cmd_next   = CH_E;
                        send       = 1'b1;
                    end
                end
                else if (s_v)
                begin
                    done       = bump_done;
                    retry_next = retry_inc;
                    send       = 1'b1;
                end
                else if (tmo)
                begin
                    done       = bump_done;
                    retry_next = retry_inc;
                    if (cmd_reg == CH_C)
                        cmd_next = CH_T;
                    send       = 1'b1;
                end

                if (rdy)
                begin
                    if (item.first_data_byte == CH_W)
                        awake_next = 1'b1;
                    else if (item.first_data_byte == CH_S)
                        awake_next = 1'b0;
                end

                deliv_next = d_v;
                seen_next  = s_v;

                if (done)
                begin
                    busy_next        = 1'b0;
                    res_valid        = 1'b1;
                    res.message_kind = (retry_next == MAX_RETRY) ? KIND_ABANDON : KIND_ACCEPT;
                    res.keep_awake   = awake_next;
                end
                else if (send)
                begin
                    deliv_next       = 1'b0;
                    seen_next        = 1'b0;
                    res_valid        = 1'b1;
                    res.message_kind = KIND_DATA;
                    res.command_char = cmd_next;
                    res.count_value  = snap_reg;
                    res.check_byte   = check_of(snap_reg);
                    res.keep_awake   = awake_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_reg <= '0;
            tick_reg  <= '0;
            busy_reg  <= 1'b0;
            snap_reg  <= '0;
            cmd_reg   <= CH_C;
            retry_reg <= '0;
            deliv_reg <= 1'b0;
            seen_reg  <= 1'b0;
            wait_reg  <= '0;
            awake_reg <= 1'b0;
        end
        else
        begin
            event_reg <= event_next;
            tick_reg  <= tick_next;
            busy_reg  <= busy_next;
            snap_reg  <= snap_next;
            cmd_reg   <= cmd_next;
            retry_reg <= retry_next;
            deliv_reg <= deliv_next;
            seen_reg  <= seen_next;
            wait_reg  <= wait_next;
            awake_reg <= awake_next;
        end
    end

endmodule

// ----- hw/rtl/crrp_out_reg.sv -----
module crrp_out_reg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  crrp_pkg::result_t                   res,
    output logic                                out_free,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [crrp_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [crrp_pkg::OUT_USER_W-1:0]     m_tuser
);
    import crrp_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign out_free   = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.message_kind;
    assign m_tdata  = {7'd0, res_reg.keep_awake, res_reg.check_byte,
                       res_reg.count_value, res_reg.command_char};

endmodule

// ----- hw/rtl/count_report_retry_protocol_top.sv -----
// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+------------------------------------------
// s_       | in  | s_tvalid/s_tready  | tuser: action; tdata: frame_type,
//          |     |                    |   delivery_status, first_data_byte
// m_       | out | m_tvalid/m_tready  | tuser: message_kind; tdata: command_char,
//          |     |                    |   count_value, check_byte, keep_awake
// cfg_     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// One item per cycle while the result register is free; results are registered out.
// The input register feeds the decision logic, which updates the state and
// loads the result register in the same cycle.
// A full result register that is not taken stalls the input register; s_tready
// then drops once it holds an item. Reset clears all counters and flags at once.
module count_report_retry_protocol_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] frame_type, [15:8] delivery_status, [23:16] first_data_byte
    input  logic [crrp_pkg::IN_DATA_W-1:0]      s_tdata,
    // [2:0] action
    input  logic [crrp_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] command_char, [39:8] count_value, [47:40] check_byte,
    // [48] keep_awake, [55:49] zero
    output logic [crrp_pkg::OUT_DATA_W-1:0]     m_tdata,
    // [1:0] message_kind
    output logic [crrp_pkg::OUT_USER_W-1:0]     m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [crrp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [crrp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import crrp_pkg::*;

    cfg_t     cfg;
    in_item_t item_reg;
    logic     in_valid_reg, in_valid_next;
    logic     out_free, fire, res_valid;
    result_t  res;

    assign fire          = in_valid_reg && out_free;
    assign s_tready      = !in_valid_reg || fire;
    assign in_valid_next = (s_tvalid && s_tready) ? 1'b1 : (fire ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.action          <= s_tuser;
            item_reg.frame_type      <= s_tdata[7:0];
            item_reg.delivery_status <= s_tdata[15:8];
            item_reg.first_data_byte <= s_tdata[23:16];
        end
    end

    crrp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crrp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    crrp_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- dv/tb_count_report_retry_protocol_top.sv -----
module tb_count_report_retry_protocol_top;

    timeunit 1ns;
    timeprecision 1ps;

    import crrp_pkg::*;

    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    localparam int N_PHASES       = 6;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_AT_REPORT = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int STALL_LIMIT    = 3000;

    typedef struct packed {
        in_item_t it;
        bit       typed;
        result_t  want;
    } stim_t;

    localparam result_t NO_REPORT = '0;

    // walk-through of one full cycle to abandon, then one to accept; ticks 0, limit 0
    localparam int N_SCRIPT = 25;
    localparam stim_t SCRIPT [N_SCRIPT] = '{
        '{'{ACT_PULSE, 8'h00, 8'h00, 8'h00}, 1'b1, NO_REPORT},
        '{'{ACT_TICK, 8'h00, 8'h00, 8'h00}, 1'b1, '{KIND_DATA, CH_C, 32'd1, 8'hFF, 1'b0}},
        '{'{ACT_POLL, 8'hFF, 8'hFF, 8'hFF}, 1'b0, NO_REPORT},
        '{'{ACT_POLL, 8'h00, 8'h00, 8'h00}, 1'b1, '{KIND_DATA, CH_T, 32'd1, 8'hFF, 1'b0}},
        '{'{ACT_GOOD, FT_STATUS, 8'h00, 8'h00}, 1'b0, NO_REPORT},
        '{'{ACT_GOOD, FT_DATA, 8'hFF, CH_W}, 1'b0, NO_REPORT},
        '{'{ACT_BAD, FT_DATA, 8'h00, 8'hFF}, 1'b0, NO_REPORT},
        '{'{ACT_GOOD, 8'hFF, 8'hFF, 8'hFF}, 1'b0, NO_REPORT},
        '{'{ACT_GOOD, FT_STATUS, 8'h00, 8'h00}, 1'b0, NO_REPORT},
        '{'{ACT_GOOD, FT_DATA, 8'h00, CH_N}, 1'b0, NO_REPORT},
        '{'{ACT_GOOD, FT_STATUS, 8'hFF, 8'h00}, 1'b1, '{KIND_ABANDON, 8'h00, 32'd0, 8'h00, 1'b1}},
        '{'{ACT_PARTIAL, 8'h00, 8'h00, 8'h00}, 1'b0, NO_REPORT},
        '{'{ACT_SPARE_7, 8'hFF, 8'hFF, 8'hFF}, 1'b0, NO_REPORT},
        '{'{ACT_POLL, 8'h00, 8'h00, 8'h00}, 1'b0, NO_REPORT},
        '{'{ACT_GOOD, FT_DATA, 8'h00, CH_A}, 1'b0, NO_REPORT},
        '{'{ACT_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, NO_REPORT},
        '{'{ACT_GOOD, FT_DATA, 8'h00, CH_N}, 1'b0, NO_REPORT},
        '{'{ACT_BAD, FT_STATUS, 8'h00, 8'h00}, 1'b0, NO_REPORT},
        '{'{ACT_GOOD, FT_STATUS, 8'h00, 8'h00}, 1'b0, NO_REPORT},
        '{'{ACT_PULSE, 8'h00, 8'h00, 8'h00}, 1'b0, NO_REPORT},
        '{'{ACT_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, NO_REPORT},
        '{'{ACT_GOOD, FT_DATA, 8'h00, CH_S}, 1'b0, NO_REPORT},
        '{'{ACT_PARTIAL, 8'h00, 8'h00, 8'h00}, 1'b0, NO_REPORT},
        '{'{ACT_GOOD, FT_DATA, 8'h00, CH_A}, 1'b1, '{KIND_ACCEPT, 8'h00, 32'd0, 8'h00, 1'b0}},
        '{'{ACT_SPARE_6, 8'h55, 8'hAA, 8'h00}, 1'b0, NO_REPORT}
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    count_report_retry_protocol_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // predicted block state and registers
    logic [EVENT_W-1:0] event_q       = '0;
    logic [TICK_W-1:0]  tick_q        = '0;
    bit                 busy_q        = 1'b0;
    logic [EVENT_W-1:0] snap_q        = '0;
    logic [7:0]         cmd_q         = CH_C;
    logic [1:0]         retries_q     = '0;
    bit                 delivered_q   = 1'b0;
    bit                 status_seen_q = 1'b0;
    logic [31:0]        poll_timer_q  = '0;
    bit                 awake_q       = 1'b0;
    logic [TICK_W-1:0]  thr_q         = TICKS_RESET;
    logic [LIMIT_W-1:0] limit_q       = LIMIT_RESET;

    stim_t   link_items_q [$];
    stim_t   items_in_flight [$];
    result_t expected_reports [$];

    int  n_queued    = 0;
    int  n_accepted  = 0;
    int  n_pending   = 0;
    int  n_effective = 0;
    int  n_errors    = 0;
    int  idle_run    = 0;
    bit  sender_calm = 1'b0;

    function automatic result_t make_report(input logic [1:0] kind);
        result_t r;
        r = '0;
        r.message_kind = kind;
        if (kind == KIND_DATA) begin
            r.command_char = cmd_q;
            r.count_value  = snap_q;
            r.check_byte   = 8'h00 - (snap_q[7:0] + snap_q[15:8] + snap_q[23:16]
                                      + snap_q[31:24]);
            delivered_q    = 1'b0;
            status_seen_q  = 1'b0;
        end
        r.keep_awake = awake_q;
        return r;
    endfunction

    function automatic bit bump_retry();
        if (retries_q < MAX_RETRY)
            retries_q = retries_q + 2'd1;
        return retries_q >= MAX_RETRY;
    endfunction

    function automatic bit advance_link(input in_item_t it, output result_t rep);
        bit rdy, err, tmo, done, send;
        rdy  = 1'b0;
        err  = 1'b0;
        tmo  = 1'b0;
        done = 1'b0;
        send = 1'b0;
        rep  = '0;
        if (it.action == ACT_PULSE || it.action == ACT_TICK)
        begin
            n_effective++;
            if (it.action == ACT_PULSE)
                event_q = event_q + 1'b1;
            else
                tick_q = tick_q + 1'b1;
            if (busy_q || tick_q <= thr_q)
                return 1'b0;
            tick_q       = '0;
            busy_q       = 1'b1;
            snap_q       = event_q;
            cmd_q        = CH_C;
            retries_q    = '0;
            poll_timer_q = '0;
            rep = make_report(KIND_DATA);
            return 1'b1;
        end
        if (!busy_q || it.action > ACT_BAD)
            return 1'b0;
        n_effective++;
        if (it.action == ACT_POLL)
        begin
            if (poll_timer_q > limit_q)
            begin
                poll_timer_q  = '0;
                tmo           = 1'b1;
                delivered_q   = 1'b0;
                status_seen_q = 1'b0;
            end
            else
            begin
                poll_timer_q = poll_timer_q + 1;
                return 1'b0;
            end
        end
        else
        begin
            poll_timer_q = '0;
            if (it.action == ACT_PARTIAL)
                return 1'b0;
            if (it.action == ACT_GOOD && it.frame_type == FT_DATA)
                rdy = 1'b1;
            else if (it.frame_type == FT_STATUS)
            begin
                delivered_q   = (it.action == ACT_GOOD) && (it.delivery_status == 8'h00);
                status_seen_q = 1'b1;
            end
            else
            begin
                err           = 1'b1;
                delivered_q   = 1'b0;
                status_seen_q = 1'b0;
            end
        end

        if (delivered_q)
        begin
            if (rdy)
            begin
                if (it.first_data_byte == CH_N)
                begin
                    done  = bump_retry();
                    cmd_q = CH_N;
                    send  = 1'b1;
                    rdy   = 1'b0;
                end
                else if (it.first_data_byte == CH_A)
                begin
                    event_q = event_q - snap_q;
                    done    = 1'b1;
                    rdy     = 1'b0;
                end
            end
            else if (err)
            begin
                done  = bump_retry();
                cmd_q = CH_E;
                send  = 1'b1;
            end
        end
        else if (status_seen_q)
        begin
            // plain resend keeps whatever command went last
            done = bump_retry();
            send = 1'b1;
        end
        else if (tmo)
        begin
            done = bump_retry();
            if (cmd_q == CH_C)
                cmd_q = CH_T;
            send = 1'b1;
        end

        if (rdy)
        begin
            if (it.first_data_byte == CH_W)
                awake_q = 1'b1;
            else if (it.first_data_byte == CH_S)
                awake_q = 1'b0;
        end

        if (done)
        begin
            busy_q = 1'b0;
            rep = make_report(retries_q >= MAX_RETRY ? KIND_ABANDON : KIND_ACCEPT);
            return 1'b1;
        end
        if (send)
        begin
            rep = make_report(KIND_DATA);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got 'h%0h, want 'h%0h", $realtime, field, got, want);
        n_errors++;
    endtask

    function automatic stim_t link_item(input logic [2:0] act, input logic [7:0] ft,
                                        input logic [7:0] ds, input logic [7:0] fb);
        stim_t rec;
        rec    = '0;
        rec.it = '{act, ft, ds, fb};
        return rec;
    endfunction

    function automatic void offer(input stim_t rec);
        link_items_q.push_back(rec);
        items_in_flight.push_back(rec);
        n_queued++;
    endfunction

    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 9))
            0, 1, 2: return CH_A;
            3, 4:    return CH_N;
            5:       return CH_W;
            6:       return CH_S;
            7:
            begin
                case ($urandom_range(0, 2))
                    0:       return CH_C;
                    1:       return CH_E;
                    default: return CH_T;
                endcase
            end
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_frame_type();
        case ($urandom_range(0, 3))
            0:       return FT_DATA;
            1:       return FT_STATUS;
            default: return 8'($urandom);
        endcase
    endfunction

    // ticks enough to open a report cycle, then a run of link events against it
    task automatic gen_session();
        int steps;
        int polls;
        sender_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0)
            offer(link_item(3'($urandom_range(2, 7)), 8'($urandom), 8'($urandom),
                            8'($urandom)));
        for (int t = 0; t <= int'(thr_q); t++)
        begin
            if ($urandom_range(0, 2) == 0)
                offer(link_item(ACT_PULSE, 8'($urandom), 8'($urandom), 8'($urandom)));
            offer(link_item(ACT_TICK, 8'($urandom), 8'($urandom), 8'($urandom)));
        end
        steps = $urandom_range(1, 8);
        for (int s = 0; s < steps; s++)
        begin
            case ($urandom_range(0, 9))
                0: offer(link_item(ACT_GOOD, FT_STATUS, 8'h00, 8'($urandom)));
                1: offer(link_item(ACT_GOOD, FT_DATA, 8'($urandom), pick_command()));
                2, 9:
                begin
                    offer(link_item(ACT_GOOD, FT_STATUS, 8'h00, 8'($urandom)));
                    offer(link_item(ACT_GOOD, FT_DATA, 8'($urandom), pick_command()));
                end
                3: offer(link_item(ACT_GOOD, FT_STATUS, 8'($urandom_range(1, 255)),
                                   8'($urandom)));
                4: offer(link_item(ACT_BAD, pick_frame_type(), 8'($urandom),
                                   pick_command()));
                5:
                begin
                    // long enough to time out when the limit is small
                    polls = (limit_q <= 40 && $urandom_range(0, 1) == 1)
                            ? int'(limit_q) + 2 : $urandom_range(1, 3);
                    repeat (polls)
                        offer(link_item(ACT_POLL, 8'($urandom), 8'($urandom),
                                        8'($urandom)));
                end
                6: offer(link_item(ACT_PARTIAL, 8'($urandom), 8'($urandom), 8'($urandom)));
                7: offer(link_item(3'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                                   8'($urandom)));
                default: offer(link_item(3'($urandom), 8'($urandom), 8'($urandom),
                                         8'($urandom)));
            endcase
        end
    endtask

    task automatic program_phase(input int thr, input int lim);
        logic [CFG_DATA_W-1:0] val [2];
        bit took;
        val[0] = CFG_DATA_W'(thr);
        val[1] = CFG_DATA_W'(lim);
        for (int r = 0; r < 2; r++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (r == 0) ? REG_TICKS_BEFORE_REPORT : REG_RESPONSE_WAIT_LIMIT;
            cfg_data  <= val[r];
            do
            begin
                @(negedge clk);
                took = cfg_ready;
                @(posedge clk);
            end
            while (!took);
        end
        cfg_valid <= 1'b0;
        thr_q   = TICK_W'(thr);
        limit_q = LIMIT_W'(lim);
    endtask

    task automatic settle();
        wait (n_accepted == n_queued && n_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // sender
    initial
    begin : sender
        stim_t rec;
        int    gap;
        bit    took;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (link_items_q.size() == 0)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (link_items_q.size() == 0)
                    @(posedge clk);
            end
            rec = link_items_q.pop_front();
            gap = sender_calm ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= rec.it.action;
            s_tdata  <= {rec.it.first_data_byte, rec.it.delivery_status, rec.it.frame_type};
            do
            begin
                @(negedge clk);
                took = s_tready;
                @(posedge clk);
            end
            while (!took);
        end
    end

    // receiver; one long hold-off to back the block up into its input
    initial
    begin : receiver
        int stall;
        int taken;
        bit calm;
        bit took;
        taken = 0;
        calm  = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (taken % 16 == 0)
                calm = ($urandom_range(0, 3) == 0);
            stall = calm ? 0 : $urandom_range(0, 14);
            if (taken == HOLD_AT_REPORT)
                stall = HOLD_CYCLES;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = m_tvalid;
                @(posedge clk);
            end
            while (!took);
            taken++;
        end
    end

    // transfers are sampled on the falling edge ahead of the rising edge that takes them
    always @(negedge clk)
    begin : watch
        bit      moved;
        bit      hit;
        stim_t   rec;
        result_t pred;
        result_t got;
        result_t want;
        moved = 1'b0;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                rec = items_in_flight.pop_front();
                hit = advance_link(rec.it, pred);
                if (rec.typed)
                begin
                    hit  = (rec.want.message_kind != KIND_NONE);
                    pred = rec.want;
                end
                if (hit)
                begin
                    expected_reports.push_back(pred);
                    n_pending++;
                end
                n_accepted++;
                moved = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                got.message_kind = m_tuser;
                got.command_char = m_tdata[7:0];
                got.count_value  = m_tdata[39:8];
                got.check_byte   = m_tdata[47:40];
                got.keep_awake   = m_tdata[48];
                if (n_pending == 0)
                    report_mismatch("unexpected report, kind", 32'(got.message_kind),
                                    32'(KIND_NONE));
                else
                begin
                    want = expected_reports.pop_front();
                    n_pending--;
                    if (got.message_kind !== want.message_kind)
                        report_mismatch("message_kind", 32'(got.message_kind),
                                        32'(want.message_kind));
                    if (got.command_char !== want.command_char)
                        report_mismatch("command_char", 32'(got.command_char),
                                        32'(want.command_char));
                    if (got.count_value !== want.count_value)
                        report_mismatch("count_value", got.count_value, want.count_value);
                    if (got.check_byte !== want.check_byte)
                        report_mismatch("check_byte", 32'(got.check_byte),
                                        32'(want.check_byte));
                    if (got.keep_awake !== want.keep_awake)
                        report_mismatch("keep_awake", 32'(got.keep_awake),
                                        32'(want.keep_awake));
                end
                moved = 1'b1;
            end
            if (cfg_valid && cfg_ready)
                moved = 1'b1;
            idle_run = moved ? 0 : idle_run + 1;
            if (idle_run >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin : main
        int thr_plan [N_PHASES];
        int lim_plan [N_PHASES];
        int items_plan [N_PHASES];
        thr_plan   = '{0, 255, 3, int'(TICKS_RESET), $urandom_range(0, 15), 1};
        lim_plan   = '{0, 65535, 4, int'(LIMIT_RESET), $urandom_range(0, 20), 2};
        // the slow-threshold phase always runs one whole session of about 350 items
        items_plan = '{170, 150, 200, 120, 190, 190};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int p = 0; p < N_PHASES; p++)
        begin
            settle();
            program_phase(thr_plan[p], lim_plan[p]);
            if (p == 0)
            begin
                sender_calm = 1'b0;
                for (int i = 0; i < N_SCRIPT; i++)
                    offer(SCRIPT[i]);
                wait (n_accepted == n_queued);
            end
            n_effective = 0;
            while (n_effective < items_plan[p])
            begin
                gen_session();
                wait (n_accepted == n_queued);
            end
        end
        settle();
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/crrp_pkg.sv
hw/rtl/crrp_cfg_regs.sv
hw/rtl/crrp_core.sv
hw/rtl/crrp_out_reg.sv
hw/rtl/count_report_retry_protocol_top.sv
dv/tb_count_report_retry_protocol_top.sv
